// ----- rtl/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// tce_pkg
// shared widths, codes and handshake structs of the text console engine
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

    // default screen store geometry
    localparam int DEF_MAX_COLS = 80;
    localparam int DEF_MAX_ROWS = 25;

    // field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    // linear cell index width, covers any area and any store size
    localparam int LIN_W = 16;

    // configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    // configuration reset values
    localparam logic [COL_W-1:0] COLUMNS_RST = 7'd80;
    localparam logic [ROW_W-1:0] ROWS_RST    = 5'd25;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // character codes and cell attribute
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CELL_ATTR  = 8'h0F;

    // request to the store walker
    typedef struct packed {
        logic go;
        logic scroll;   // 1 scroll up one row, 0 zero the whole store
    } walk_req_t;

    // walker access stream toward the store
    typedef struct packed {
        logic             busy;
        logic             rd_en;
        logic [LIN_W-1:0] rd_addr;
        logic             wr_en;
        logic [LIN_W-1:0] wr_addr;
        logic             wr_copy;  // 1 write read data, 0 write zero
    } walk_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/tce_ram.sv -----
// ----------------------------------------------------------------------------
// tce_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tce_walker.sv -----
// ----------------------------------------------------------------------------
// tce_walker
// sweeps the screen store for a one row scroll or a full clear
// ----------------------------------------------------------------------------
`default_nettype none

module tce_walker
    import tce_pkg::*;
#(
    parameter int CELL_COUNT = DEF_MAX_COLS * DEF_MAX_ROWS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire walk_req_t        req,
    input  wire logic [COL_W-1:0] cols,
    input  wire logic [LIN_W-1:0] area,
    output walk_ctl_t             ctl
);

    localparam logic [LIN_W-1:0] CELLS = LIN_W'(CELL_COUNT);

    logic             run_reg,    run_next;
    logic             scroll_reg, scroll_next;
    logic [LIN_W-1:0] p_reg,      p_next;
    logic [LIN_W-1:0] end_reg,    end_next;
    logic             pend_reg,   pend_next;
    logic [LIN_W-1:0] pd_reg,     pd_next;
    logic             copy_reg,   copy_next;
    logic [LIN_W-1:0] src;
    logic             rd_en;

    // source of the copy lies one row below the destination
    assign src   = p_reg + {{(LIN_W-COL_W){1'b0}}, cols};
    assign rd_en = run_reg && scroll_reg && (src < end_reg);

    always_comb
    begin
        run_next    = run_reg;
        scroll_next = scroll_reg;
        p_next      = p_reg;
        end_next    = end_reg;
        if (req.go)
        begin
            run_next    = 1'b1;
            scroll_next = req.scroll;
            p_next      = '0;
            end_next    = req.scroll ? area : CELLS;
        end
        else if (run_reg)
        begin
            p_next = p_reg + LIN_W'(1);
            if (p_reg == end_reg - LIN_W'(1))
            begin
                run_next = 1'b0;
            end
        end
        // write trails the read by the ram latency
        pend_next = run_reg;
        pd_next   = p_reg;
        copy_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // a clear pass runs straight out of reset
            run_reg    <= 1'b1;
            scroll_reg <= 1'b0;
            p_reg      <= '0;
            end_reg    <= CELLS;
            pend_reg   <= 1'b0;
        end
        else
        begin
            run_reg    <= run_next;
            scroll_reg <= scroll_next;
            p_reg      <= p_next;
            end_reg    <= end_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pd_reg   <= pd_next;
        copy_reg <= copy_next;
    end

    always_comb
    begin
        ctl.busy    = run_reg | pend_reg;
        ctl.rd_en   = rd_en;
        ctl.rd_addr = src;
        ctl.wr_en   = pend_reg;
        ctl.wr_addr = pd_reg;
        ctl.wr_copy = copy_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/text_console_engine_core.sv -----
// ----------------------------------------------------------------------------
// text_console_engine_core
// text mode console: screen store of attribute/character cells plus cursor
// ----------------------------------------------------------------------------
// usage
//   s_* carries commands: tuser is the command (put, read, clear), tdata the
//   character byte and the cell index. m_* returns one item per command with
//   the cell read, the cursor after the command and a scroll flag.
//   cfg_we/cfg_index/cfg_wdata set columns (index 0) and rows (index 1) while
//   the block is idle; 0 acts as 1, above the store as max (rows use bits 4:0).
// sequence, from accept to result on m_*
//   put: cursor index, cell write (a tab adds a second space), cursor advance
//   and a scroll pass if the cursor runs off the last row; read: store read and
//   capture; clear: a whole-store sweep; unknown command: straight to result.
//   one item is in work at a time, the next is taken on the cycle after its
//   result is loaded; sweeps run one cell per cycle via the single write port.
// reset
//   the cursor goes home, the registers to 80x25, and a clear pass zeroes
//   the store; s_tready stays low meanwhile.
// stall
//   the result waits in the output register; the block takes one more item
//   and holds its result until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_engine_core
    import tce_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_wdata,
    // command input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // cell_value[15:0], cursor_col[22:16],
                                        // cursor_row[27:23], scrolled[28], zero
);

    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam logic [LIN_W-1:0] CELLS = LIN_W'(CELL_COUNT);
    localparam logic [8:0] MAXC = 9'(MAX_COLS);
    localparam logic [7:0] MAXR = 8'(MAX_ROWS);

    typedef enum logic [9:0] {
        S_INIT = 10'b0000000001,  // reset clear pass
        S_IDLE = 10'b0000000010,
        S_ADDR = 10'b0000000100,  // linear index of the cursor
        S_WR1  = 10'b0000001000,  // first cell write
        S_WR2  = 10'b0000010000,  // second tab space
        S_ADV  = 10'b0000100000,  // cursor advance, wrap, scroll
        S_WALK = 10'b0001000000,  // scroll or clear sweep
        S_RD   = 10'b0010000000,
        S_RCAP = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [COL_W-1:0] columns_reg;
    logic [ROW_W-1:0] rows_reg;
    logic [COL_W-1:0] eff_cols;
    logic [ROW_W-1:0] eff_rows;
    logic [LIN_W-1:0] area_reg;

    // command and cursor
    logic [CHAR_W-1:0] ch_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  line_reg, line_next;
    logic [LIN_W-1:0]  lin_reg;
    logic [CELL_W-1:0] value_reg;
    logic              scrolled_reg;
    logic              scroll_now;

    // output register
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;

    // store access
    walk_req_t         walk_req;
    walk_ctl_t         walk;
    logic              ram_we, ram_re;
    logic [LIN_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;
    logic              put_we;
    logic              is_tab, is_glyph;
    logic              accept;
    logic              out_free;

    // register clamp to the store geometry
    always_comb
    begin
        if (columns_reg == '0)
        begin
            eff_cols = COL_W'(1);
        end
        else if ({2'b00, columns_reg} > MAXC)
        begin
            eff_cols = MAXC[COL_W-1:0];
        end
        else
        begin
            eff_cols = columns_reg;
        end
        if (rows_reg == '0)
        begin
            eff_rows = ROW_W'(1);
        end
        else if ({3'b000, rows_reg} > MAXR)
        begin
            eff_rows = MAXR[ROW_W-1:0];
        end
        else
        begin
            eff_rows = rows_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RST;
            rows_reg    <= ROWS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLUMNS: columns_reg <= cfg_wdata;
                CFG_ROWS:    rows_reg    <= cfg_wdata[ROW_W-1:0];
                default:     ;
            endcase
        end
    end

    // cells in use, refreshed every cycle; user sets config only when idle, unchecked
    always_ff @(posedge clk)
    begin
        area_reg <= LIN_W'(eff_cols) * LIN_W'(eff_rows);
    end

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign is_tab   = (ch_reg == CH_TAB);
    assign is_glyph = (ch_reg != CH_NUL) && (ch_reg != CH_NEWLINE);

    // cursor advance, column wrap and row overflow
    always_comb
    begin
        logic [COL_W:0]   c;
        logic [ROW_W:0]   l;
        c = {1'b0, col_reg};
        l = {1'b0, line_reg};
        if (ch_reg == CH_NEWLINE)
        begin
            c = '0;
            l = l + (ROW_W+1)'(1);
        end
        else if (is_tab)
        begin
            c = c + (COL_W+1)'(2);
        end
        else if (is_glyph)
        begin
            c = c + (COL_W+1)'(1);
        end
        if (c >= {1'b0, eff_cols})
        begin
            c = '0;
            l = l + (ROW_W+1)'(1);
        end
        scroll_now = 1'b0;
        if (l >= {1'b0, eff_rows})
        begin
            l          = {1'b0, eff_rows - ROW_W'(1)};
            c          = '0;
            scroll_now = 1'b1;
        end
        col_next  = c[COL_W-1:0];
        line_next = l[ROW_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        walk_req.go     = 1'b0;
        walk_req.scroll = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                if (!walk.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        CMD_PUT:   state_next = S_ADDR;
                        CMD_READ:  state_next = S_RD;
                        CMD_CLEAR:
                        begin
                            walk_req.go = 1'b1;
                            state_next  = S_WALK;
                        end
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_ADDR: state_next = S_WR1;
            S_WR1:  state_next = is_tab ? S_WR2 : S_ADV;
            S_WR2:  state_next = S_ADV;
            S_ADV:
            begin
                if (scroll_now)
                begin
                    walk_req.go     = 1'b1;
                    walk_req.scroll = 1'b1;
                    state_next      = S_WALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                if (!walk.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_RD:   state_next = S_RCAP;
            S_RCAP: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            col_reg      <= '0;
            line_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ADV)
            begin
                col_reg  <= col_next;
                line_reg <= line_next;
            end
            if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // item payload and per-item results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg       <= s_tdata[7:0];
            idx_reg      <= s_tdata[18:8];
            value_reg    <= '0;
            scrolled_reg <= 1'b0;
        end
        if (state_reg == S_ADDR)
        begin
            lin_reg <= {{(LIN_W-COL_W){1'b0}}, col_reg}
                     + LIN_W'(line_reg) * LIN_W'(eff_cols);
        end
        if (state_reg == S_ADV)
        begin
            scrolled_reg <= scroll_now;
        end
        if (state_reg == S_RCAP && {{(LIN_W-IDX_W){1'b0}}, idx_reg} < CELLS)
        begin
            value_reg <= ram_rdata;
        end
        if (state_reg == S_DONE && out_free)
        begin
            m_tdata_reg <= {3'b000, scrolled_reg, line_reg, col_reg, value_reg};
        end
    end

    // store port selection: sweep first, then the put writes
    always_comb
    begin
        put_we = 1'b0;
        if (state_reg == S_WR1)
        begin
            put_we = is_glyph && (lin_reg < area_reg);
        end
        else if (state_reg == S_WR2)
        begin
            put_we = (lin_reg + LIN_W'(1)) < area_reg;
        end

        ram_we    = walk.wr_en | put_we;
        ram_waddr = walk.wr_en ? walk.wr_addr
                  : (state_reg == S_WR2) ? lin_reg + LIN_W'(1) : lin_reg;
        if (walk.wr_en)
        begin
            ram_wdata = walk.wr_copy ? ram_rdata : '0;
        end
        else if (is_tab)
        begin
            ram_wdata = {CELL_ATTR, CH_SPACE};
        end
        else
        begin
            ram_wdata = {CELL_ATTR, ch_reg};
        end

        ram_re    = walk.rd_en | (state_reg == S_RD);
        ram_raddr = walk.rd_en ? walk.rd_addr
                  : {{(LIN_W-IDX_W){1'b0}}, idx_reg};
    end

    tce_walker #(
        .CELL_COUNT(CELL_COUNT)
    ) u_walker (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (walk_req),
        .cols (eff_cols),
        .area (area_reg),
        .ctl  (walk)
    );

    tce_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr[AW-1:0]),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // no command taken while a sweep owns the store
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        walk.busy |-> !s_tready)
        else $error("item accepted during a store sweep");

    // sweep writes and cursor writes never collide on the write port
    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(walk.wr_en && put_we))
        else $error("sweep and put write in the same cycle");

    // a sweep is only started from idle or from the cursor advance step
    a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
        walk_req.go |-> (state_reg == S_IDLE || state_reg == S_ADV))
        else $error("sweep started from an unexpected step");

    // the cursor only moves in the advance step
    a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) != S_ADV) |-> ($stable(col_reg) && $stable(line_reg)))
        else $error("cursor changed outside the advance step");

endmodule

`default_nettype wire
